[rtl/battery_soc_estimator_defines.svh]
// Assertion macros for the battery SOC estimator.
// Depends on a clock named clock and an active-high reset named reset in the using module.
`ifndef BATTERY_SOC_ESTIMATOR_DEFINES_SVH
`define BATTERY_SOC_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bse_pkg.sv]
// Package for the battery SOC estimator: state encoding, register indexes,
// fixed-point constants and the open-circuit-voltage curve. No dependencies.
package bse_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CURVE_POINTS = 13;

   localparam logic [19:0] UOHM_PER_OHM = 20'd1000000;
   localparam logic [16:0] GAIN_ONE     = 17'd65536;
   localparam logic [35:0] RES_RESET    = 36'd150000 << FRAC_BITS;

   localparam logic [2:0] REG_INIT_RES  = 3'd0;
   localparam logic [2:0] REG_STEP_THR  = 3'd1;
   localparam logic [2:0] REG_RES_MIN   = 3'd2;
   localparam logic [2:0] REG_RES_MAX   = 3'd3;
   localparam logic [2:0] REG_RES_GAIN  = 3'd4;
   localparam logic [2:0] REG_SOC_GAIN  = 3'd5;

   typedef enum logic [15:0] {
      ST_IDLE   = 16'h0001,
      ST_DECIDE = 16'h0002,
      ST_NUM    = 16'h0004,
      ST_LO     = 16'h0008,
      ST_HI     = 16'h0010,
      ST_RDIV   = 16'h0020,
      ST_REMA1  = 16'h0040,
      ST_REMA2  = 16'h0080,
      ST_CMUL   = 16'h0100,
      ST_CDIV   = 16'h0200,
      ST_SEARCH = 16'h0400,
      ST_PMUL   = 16'h0800,
      ST_PDIV   = 16'h1000,
      ST_SEMA1  = 16'h2000,
      ST_SEMA2  = 16'h4000,
      ST_DONE   = 16'h8000
   } state_type;

   // Curve voltage in mV, highest point first.
   function automatic logic [12:0] curve_mv(input logic [3:0] idx);
      logic [12:0] v;
      case (idx)
         4'd0:    v = 13'd4200;
         4'd1:    v = 13'd4100;
         4'd2:    v = 13'd4060;
         4'd3:    v = 13'd3980;
         4'd4:    v = 13'd3920;
         4'd5:    v = 13'd3870;
         4'd6:    v = 13'd3820;
         4'd7:    v = 13'd3790;
         4'd8:    v = 13'd3750;
         4'd9:    v = 13'd3700;
         4'd10:   v = 13'd3600;
         4'd11:   v = 13'd3500;
         4'd12:   v = 13'd3300;
         default: v = 13'd0;
      endcase
      return v;
   endfunction

   // Curve SOC in centi-percent, matching curve_mv.
   function automatic logic [13:0] curve_soc(input logic [3:0] idx);
      logic [13:0] s;
      case (idx)
         4'd0:    s = 14'd10000;
         4'd1:    s = 14'd9500;
         4'd2:    s = 14'd9000;
         4'd3:    s = 14'd8000;
         4'd4:    s = 14'd7000;
         4'd5:    s = 14'd6000;
         4'd6:    s = 14'd5000;
         4'd7:    s = 14'd4000;
         4'd8:    s = 14'd3000;
         4'd9:    s = 14'd2000;
         4'd10:   s = 14'd1000;
         4'd11:   s = 14'd500;
         4'd12:   s = 14'd0;
         default: s = 14'd0;
      endcase
      return s;
   endfunction

endpackage

[rtl/battery_soc_estimator.sv]
// Battery SOC estimator top level: sequencer, serial multiplier and serial divider.
// Depends on bse_pkg and battery_soc_estimator_defines.svh.
//
// Usage:
//  - req channel: one beat carries req_vbat_mv (mV) and req_current_ma (signed mA).
//    A beat is taken when req_valid is high and req_stall is low.
//  - rsp channel: one beat per request with rsp_soc_centi_pct and rsp_resistance_uohm.
//  - csr: APB-style port, register i at byte address 4*i, pready tied high.
//  - Timing: each product runs on the shared shift-add multiplier, and each restoring
//    division yields one quotient bit per cycle (for the IR drop, the curve
//    interpolation and a resistance sample); the curve search walks one segment per
//    cycle. A resistance update adds up to five products and a division; the SOC
//    blend adds two products once the filter is seeded.
//  - One beat is in flight at a time; req_stall is low only in idle, so the next
//    beat can be taken once the result is loaded and rsp_valid rises.
//  - The result sits in an output register, so the next request is accepted
//    while rsp_stall holds the previous result; a finished result waits in
//    the done state until the output register frees up.
//  - Reset (synchronous) loads register defaults, the default resistance,
//    clears the SOC filter and the previous sample, and empties the output.
`include "battery_soc_estimator_defines.svh"

module battery_soc_estimator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic        [12:0] req_vbat_mv,
   input  logic signed [14:0] req_current_ma,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [13:0] rsp_soc_centi_pct,
   output logic        [19:0] rsp_resistance_uohm,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic        [4:0]  paddr,
   input  logic        [31:0] pwdata,
   output logic        [31:0] prdata,
   output logic               pready
);
   import bse_pkg::*;

   // configuration registers
   logic [19:0] init_res_ff;
   logic [13:0] thr_ff;
   logic [19:0] rmin_ff;
   logic [19:0] rmax_ff;
   logic [16:0] gr_ff;
   logic [16:0] gs_ff;

   // estimator state
   logic        [12:0] prev_v_ff;
   logic signed [14:0] prev_c_ff;
   logic        [35:0] res_ff, res_in;
   logic        [29:0] filt_ff, filt_in;
   logic               seeded_ff, seeded_in;

   // per-beat working registers
   logic        [12:0] vb_ff;
   logic signed [14:0] cur_ff;
   logic        [15:0] den_ff;
   logic        [12:0] adv_ff;
   logic               try_ff;
   logic        [32:0] num_ff, num_in;
   logic signed [33:0] ocv_ff, ocv_in;
   logic        [3:0]  seg_ff, seg_in;
   state_type          state_ff, state_in;

   // serial multiplier
   logic [53:0] ma_ff, acc_ff;
   logic [16:0] mb_ff;
   logic [4:0]  mcnt_ff;
   logic        mul_go, mul_clr;
   logic [35:0] mul_a;
   logic [16:0] mul_b;

   // serial divider
   logic [19:0] rem_ff, dd_ff;
   logic [51:0] dn_ff;
   logic [35:0] quo_ff;
   logic [5:0]  dcnt_ff;
   logic        div_go;
   logic [19:0] div_rem0, div_den;
   logic [51:0] div_num0;
   logic [5:0]  div_cnt;

   // output register
   logic        rsp_valid_ff;
   logic [13:0] soc_out_ff;
   logic [19:0] r_out_ff;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   logic       cfg_wr;
   logic [2:0] cfg_idx;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = paddr[4:2];
   assign pready  = 1'b1;

   always_comb begin
      case (cfg_idx)
         REG_INIT_RES: prdata = {12'd0, init_res_ff};
         REG_STEP_THR: prdata = {18'd0, thr_ff};
         REG_RES_MIN:  prdata = {12'd0, rmin_ff};
         REG_RES_MAX:  prdata = {12'd0, rmax_ff};
         REG_RES_GAIN: prdata = {15'd0, gr_ff};
         REG_SOC_GAIN: prdata = {15'd0, gs_ff};
         default:      prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Input beat decode: step detection against the previous sample
   // ---------------------------------------------------------------------
   logic signed [16:0] di;
   logic signed [13:0] dv;
   logic        [15:0] adi;
   logic        [12:0] adv;
   logic               try_now;
   logic               req_take;

   assign req_take = req_valid && !req_stall;
   assign di  = 17'(req_current_ma) - 17'(prev_c_ff);
   assign dv  = $signed({1'b0, req_vbat_mv}) - $signed({1'b0, prev_v_ff});
   assign adi = di[16] ? 16'(-di) : di[15:0];
   assign adv = dv[13] ? 13'(-dv) : dv[12:0];
   // only a positive dV/dI can land strictly between two nonnegative limits
   assign try_now = (prev_v_ff != 13'd0) && (adi > {2'b00, thr_ff}) && (dv != 14'sd0) &&
                    (dv[13] == di[16]);

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   logic [16:0] gr_sat, gs_sat;
   logic [14:0] acur;
   logic [53:0] ema_sum;
   logic [37:0] ema_w;
   logic        mul_done, div_done;
   logic        cmul_go, soc_go;
   logic [35:0] cmul_a;
   logic [29:0] inst;
   logic [51:0] dnum;
   logic [33:0] corr_ext, vq;
   logic signed [33:0] top_q, bot_q, lo_q, ocv_diff;
   logic [3:0]  seg_nx;
   logic [13:0] ds;
   logic [12:0] dvseg;

   assign gr_sat   = (gr_ff > GAIN_ONE) ? GAIN_ONE : gr_ff;
   assign gs_sat   = (gs_ff > GAIN_ONE) ? GAIN_ONE : gs_ff;
   assign acur     = cur_ff[14] ? 15'(-cur_ff) : cur_ff[14:0];
   assign ema_sum  = acc_ff + 54'd32768;
   assign ema_w    = ema_sum[53:16];
   assign mul_done = (mcnt_ff == 5'd0);
   assign div_done = (dcnt_ff == 6'd0);
   assign seg_nx   = seg_ff + 4'd1;
   assign top_q    = $signed({5'd0, curve_mv(4'd0), 16'd0});
   assign bot_q    = $signed({5'd0, curve_mv(4'(CURVE_POINTS - 1)), 16'd0});
   assign lo_q     = $signed({5'd0, curve_mv(seg_nx), 16'd0});
   assign ocv_diff = ocv_ff - lo_q;
   assign ds       = curve_soc(seg_ff) - curve_soc(seg_nx);
   assign dvseg    = curve_mv(seg_ff) - curve_mv(seg_nx);
   assign corr_ext = {2'd0, quo_ff[31:0]};
   assign vq       = {5'd0, vb_ff, 16'd0};

   always_comb begin
      state_in  = state_ff;
      res_in    = res_ff;
      filt_in   = filt_ff;
      seeded_in = seeded_ff;
      num_in    = num_ff;
      ocv_in    = ocv_ff;
      seg_in    = seg_ff;
      mul_go    = 1'b0;
      mul_clr   = 1'b1;
      mul_a     = 36'd0;
      mul_b     = 17'd0;
      div_go    = 1'b0;
      div_rem0  = 20'd0;
      div_num0  = 52'd0;
      div_den   = 20'd1;
      div_cnt   = 6'd0;
      cmul_go   = 1'b0;
      cmul_a    = res_ff;
      soc_go    = 1'b0;
      inst      = 30'd0;
      dnum      = 52'd0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (try_ff) begin
               mul_go   = 1'b1;
               mul_a    = {16'd0, UOHM_PER_OHM};
               mul_b    = {4'd0, adv_ff};
               state_in = ST_NUM;
            end else begin
               cmul_go = 1'b1;
            end
         end
         ST_NUM: begin
            if (mul_done) begin
               num_in   = acc_ff[32:0];
               mul_go   = 1'b1;
               mul_a    = {16'd0, rmin_ff};
               mul_b    = {1'b0, den_ff};
               state_in = ST_LO;
            end
         end
         ST_LO: begin
            if (mul_done) begin
               if ({4'd0, num_ff} > acc_ff[36:0]) begin
                  mul_go   = 1'b1;
                  mul_a    = {16'd0, rmax_ff};
                  mul_b    = {1'b0, den_ff};
                  state_in = ST_HI;
               end else begin
                  cmul_go = 1'b1;
               end
            end
         end
         ST_HI: begin
            if (mul_done) begin
               if ({4'd0, num_ff} < acc_ff[36:0]) begin
                  // r = (num << F + den/2) / den, quotient below 2^36
                  dnum     = {3'd0, num_ff, 16'd0} + {36'd0, 1'b0, den_ff[15:1]};
                  div_go   = 1'b1;
                  div_rem0 = {4'd0, dnum[51:36]};
                  div_num0 = {dnum[35:0], 16'd0};
                  div_den  = {4'd0, den_ff};
                  div_cnt  = 6'd36;
                  state_in = ST_RDIV;
               end else begin
                  cmul_go = 1'b1;
               end
            end
         end
         ST_RDIV: begin
            if (div_done) begin
               mul_go   = 1'b1;
               mul_a    = quo_ff;
               mul_b    = gr_sat;
               state_in = ST_REMA1;
            end
         end
         ST_REMA1: begin
            if (mul_done) begin
               mul_go   = 1'b1;
               mul_clr  = 1'b0;
               mul_a    = res_ff;
               mul_b    = GAIN_ONE - gr_sat;
               state_in = ST_REMA2;
            end
         end
         ST_REMA2: begin
            if (mul_done) begin
               res_in  = ema_w[35:0];
               cmul_go = 1'b1;
               cmul_a  = ema_w[35:0];
            end
         end
         ST_CMUL: begin
            if (mul_done) begin
               // IR drop in mV Q16: (|I| * R + 500000) / 1e6, below 2^32
               dnum     = {1'b0, acc_ff[50:0]} + 52'd500000;
               div_go   = 1'b1;
               div_rem0 = dnum[51:32];
               div_num0 = {dnum[31:0], 20'd0};
               div_den  = UOHM_PER_OHM;
               div_cnt  = 6'd32;
               state_in = ST_CDIV;
            end
         end
         ST_CDIV: begin
            if (div_done) begin
               if (!cur_ff[14] && (cur_ff != 15'sd0)) begin
                  ocv_in = $signed(vq - corr_ext);
               end else begin
                  ocv_in = $signed(vq + corr_ext);
               end
               seg_in   = 4'd0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (ocv_ff >= top_q) begin
               soc_go = 1'b1;
               inst   = {curve_soc(4'd0), 16'd0};
            end else if (ocv_ff <= bot_q) begin
               soc_go = 1'b1;
               inst   = 30'd0;
            end else if (ocv_ff >= lo_q) begin
               mul_go   = 1'b1;
               mul_a    = {12'd0, ocv_diff[23:0]};
               mul_b    = {3'd0, ds};
               state_in = ST_PMUL;
            end else begin
               seg_in = seg_nx;
            end
         end
         ST_PMUL: begin
            if (mul_done) begin
               dnum     = {17'd0, acc_ff[34:0]} + {39'd0, 1'b0, dvseg[12:1]};
               div_go   = 1'b1;
               div_rem0 = dnum[45:26];
               div_num0 = {dnum[25:0], 26'd0};
               div_den  = {7'd0, dvseg};
               div_cnt  = 6'd26;
               state_in = ST_PDIV;
            end
         end
         ST_PDIV: begin
            if (div_done) begin
               soc_go = 1'b1;
               inst   = {curve_soc(seg_nx), 16'd0} + {4'd0, quo_ff[25:0]};
            end
         end
         ST_SEMA1: begin
            if (mul_done) begin
               mul_go   = 1'b1;
               mul_clr  = 1'b0;
               mul_a    = {6'd0, filt_ff};
               mul_b    = GAIN_ONE - gs_sat;
               state_in = ST_SEMA2;
            end
         end
         ST_SEMA2: begin
            if (mul_done) begin
               filt_in  = ema_w[29:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // start the IR-drop product
      if (cmul_go) begin
         mul_go   = 1'b1;
         mul_clr  = 1'b1;
         mul_a    = cmul_a;
         mul_b    = {2'd0, acur};
         state_in = ST_CMUL;
      end

      // seed the filter on the first beat, blend afterwards
      if (soc_go) begin
         if (!seeded_ff) begin
            filt_in   = inst;
            seeded_in = 1'b1;
            state_in  = ST_DONE;
         end else begin
            mul_go   = 1'b1;
            mul_clr  = 1'b1;
            mul_a    = {6'd0, inst};
            mul_b    = gs_sat;
            state_in = ST_SEMA1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Control and estimator state
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         init_res_ff  <= 20'd150000;
         thr_ff       <= 14'd200;
         rmin_ff      <= 20'd20000;
         rmax_ff      <= 20'd500000;
         gr_ff        <= 17'd13107;
         gs_ff        <= 17'd3277;
         prev_v_ff    <= 13'd0;
         prev_c_ff    <= 15'sd0;
         res_ff       <= RES_RESET;
         filt_ff      <= 30'd0;
         seeded_ff    <= 1'b0;
         state_ff     <= ST_IDLE;
         mcnt_ff      <= 5'd0;
         dcnt_ff      <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         res_ff    <= res_in;
         filt_ff   <= filt_in;
         seeded_ff <= seeded_in;

         if (cfg_wr) begin
            case (cfg_idx)
               REG_INIT_RES: begin
                  init_res_ff <= pwdata[19:0];
                  res_ff      <= {pwdata[19:0], 16'd0};
               end
               REG_STEP_THR: thr_ff  <= pwdata[13:0];
               REG_RES_MIN:  rmin_ff <= pwdata[19:0];
               REG_RES_MAX:  rmax_ff <= pwdata[19:0];
               REG_RES_GAIN: gr_ff   <= pwdata[16:0];
               REG_SOC_GAIN: gs_ff   <= pwdata[16:0];
               default: ;
            endcase
         end

         if (req_take) begin
            prev_v_ff <= req_vbat_mv;
            prev_c_ff <= req_current_ma;
         end

         // multiplier sequencing
         if (mul_go) begin
            mcnt_ff <= 5'd17;
         end else if (!mul_done) begin
            mcnt_ff <= mcnt_ff - 5'd1;
         end

         // divider sequencing
         if (div_go) begin
            dcnt_ff <= div_cnt;
         end else if (!div_done) begin
            dcnt_ff <= dcnt_ff - 6'd1;
         end

         // drop the beat once taken, raise it when a result is loaded
         if ((state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Datapath registers
   // ---------------------------------------------------------------------
   logic [20:0] r2;
   logic        r2_ge;
   logic [14:0] soc_round;
   logic [20:0] r_round;

   assign r2        = {rem_ff, dn_ff[51]};
   assign r2_ge     = (r2 >= {1'b0, dd_ff});
   assign soc_round = 15'(({1'b0, filt_ff} + 31'd32768) >> 16);
   assign r_round   = 21'(({1'b0, res_ff} + 37'd32768) >> 16);

   always_ff @(posedge clock) begin
      if (req_take) begin
         vb_ff  <= req_vbat_mv;
         cur_ff <= req_current_ma;
         den_ff <= adi;
         adv_ff <= adv;
         try_ff <= try_now;
      end
      num_ff <= num_in;
      ocv_ff <= ocv_in;
      seg_ff <= seg_in;

      // shift-add multiplier: one multiplier bit per cycle
      if (mul_go) begin
         ma_ff <= {18'd0, mul_a};
         mb_ff <= mul_b;
         if (mul_clr) begin
            acc_ff <= 54'd0;
         end
      end else if (!mul_done) begin
         if (mb_ff[0]) begin
            acc_ff <= acc_ff + ma_ff;
         end
         ma_ff <= {ma_ff[52:0], 1'b0};
         mb_ff <= {1'b0, mb_ff[16:1]};
      end

      // restoring divider: one quotient bit per cycle
      if (div_go) begin
         rem_ff <= div_rem0;
         dn_ff  <= div_num0;
         dd_ff  <= div_den;
         quo_ff <= 36'd0;
      end else if (!div_done) begin
         rem_ff <= r2_ge ? 20'(r2 - {1'b0, dd_ff}) : r2[19:0];
         dn_ff  <= {dn_ff[50:0], 1'b0};
         quo_ff <= {quo_ff[34:0], r2_ge};
      end

      // output register, saturated to the field widths
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall)) begin
         soc_out_ff <= soc_round[14] ? 14'h3FFF : soc_round[13:0];
         r_out_ff   <= r_round[20] ? 20'hFFFFF : r_round[19:0];
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_soc_centi_pct   = soc_out_ff;
   assign rsp_resistance_uohm = r_out_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `BSE_ASSERT_NOW(a_units_exclusive, mcnt_ff != 5'd0, dcnt_ff == 6'd0, "multiplier and divider busy together")
   `BSE_ASSERT_NEXT(a_accept_decide, req_valid && !req_stall, state_ff == ST_DECIDE, "accepted beat did not reach decode")
   `BSE_ASSERT_NOW(a_seg_range, state_ff == ST_SEARCH, seg_ff < 4'd12, "curve segment search ran past the last segment")
   `BSE_ASSERT_NEXT(a_done_loads, (state_ff == ST_DONE) && !(rsp_valid_ff && rsp_stall), rsp_valid_ff && (state_ff == ST_IDLE), "finished result not loaded")

endmodule
